// ===== sv/dirty_tile_rect_tracker_assert.svh =====
// Assertion macros for the dirty tile rectangle tracker.
`ifndef DIRTY_TILE_RECT_TRACKER_ASSERT_SVH
`define DIRTY_TILE_RECT_TRACKER_ASSERT_SVH

// Check that a condition implies a result in the same cycle.
`define DTR_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("dtr assertion failed");

// Check that a condition implies a result in the next cycle.
`define DTR_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("dtr assertion failed");

`endif

// ===== sv/dtr_pkg.sv =====
// Package with types and constants of the dirty tile rectangle tracker.
`default_nettype none
package dtr_pkg;
   localparam int unsigned PIX_W   = 13;
   localparam int unsigned SHIFT_W = 4;
   localparam int unsigned DIM_W   = 6;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned SHIFT_MAX = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS       = 2'd2;

   localparam logic OP_MARK = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
endpackage
`default_nettype wire

// ===== sv/dirty_tile_rect_tracker.sv =====
// Dirty tile rectangle tracker: tile bitmap in a row memory with mark and take sequencer.
//
// The tile map sits in one synchronous memory, one word of MAX_COLS bits per tile row.
// A mark item reads, then writes back, each tile row word it covers; a reversed rectangle
// finishes at once. A take item scans rows from the top, one row read a cycle, until the
// first dirty row; the run and the rightward growth then read each further row of the run
// and the row below it, if in use, once, and clearing reads and writes back each row of
// the run. The result strobe rsp_valid is high for one cycle and cannot be stalled; busy
// stays high until the item is finished, including the result cycle. After reset a
// clearing pass writes every row word once with busy high; configuration writes are
// accepted throughout and must only be made while no item is in work.
`default_nettype none
`include "dirty_tile_rect_tracker_assert.svh"
module dirty_tile_rect_tracker #(
   parameter int unsigned MAX_COLS = 32,
   parameter int unsigned MAX_ROWS = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire                              req_opcode,
   input  wire  [dtr_pkg::PIX_W-1:0]        req_x_first,
   input  wire  [dtr_pkg::PIX_W-1:0]        req_y_first,
   input  wire  [dtr_pkg::PIX_W-1:0]        req_x_last,
   input  wire  [dtr_pkg::PIX_W-1:0]        req_y_last,
   output logic                             rsp_valid,
   output logic                             rsp_rect_found,
   output logic [dtr_pkg::PIX_W-1:0]        rsp_x_start,
   output logic [dtr_pkg::PIX_W-1:0]        rsp_y_start,
   output logic [dtr_pkg::PIX_W-1:0]        rsp_x_end,
   output logic [dtr_pkg::PIX_W-1:0]        rsp_y_end,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [dtr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [7:0]                       csr_wdata
);
   import dtr_pkg::*;

   localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   // Counters that can hold the dimension itself.
   localparam int unsigned CN = $clog2(MAX_COLS + 1);
   localparam int unsigned RN = $clog2(MAX_ROWS + 1);
   localparam int unsigned DW = (CN > RN ? CN : RN) > DIM_W ? (CN > RN ? CN : RN) : DIM_W;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_MARK  = 10'b0000000100,
      ST_SCAN  = 10'b0000001000,
      ST_FIND  = 10'b0000010000,
      ST_RUN   = 10'b0000100000,
      ST_GROW  = 10'b0001000000,
      ST_WIPE  = 10'b0010000000,
      ST_DONE  = 10'b0100000000,
      ST_EMPTY = 10'b1000000000
   } state_type;

   // Tile map memory, one word per tile row.
   logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                mem_we;
   logic [RW-1:0]       mem_waddr;
   logic [MAX_COLS-1:0] mem_wdata;
   logic                mem_re;
   logic [RW-1:0]       mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   state_type           state_ff, state_in;
   logic [SHIFT_W-1:0]  shift_ff;
   logic [DIM_W-1:0]    cols_cfg_ff, rows_cfg_ff;
   logic [RN-1:0]       row_ff, row_in;       // row issued for read or write
   logic                rv_ff, rv_in;         // read issued last cycle
   logic [RW-1:0]       rrow_ff, rrow_in;     // row whose data arrives now
   logic [CW-1:0]       x0_ff, x0_in, x1_ff, x1_in;
   logic [RW-1:0]       y1_ff, y1_in;
   logic [RW-1:0]       sy_ff, sy_in, ey_ff, ey_in;
   logic [MAX_COLS-1:0] mask_ff, mask_in;     // columns still in the growing group
   logic [MAX_COLS-1:0] cmask_ff;             // columns in use

   // Effective configuration.
   logic [SHIFT_W-1:0]  sh;
   logic [DW-1:0]       cols_e, rows_e;
   always_comb begin
      sh = (shift_ff > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : shift_ff;
      cols_e = DW'(cols_cfg_ff);
      if (cols_e == '0) cols_e = DW'(1);
      if (cols_e > DW'(MAX_COLS)) cols_e = DW'(MAX_COLS);
      rows_e = DW'(rows_cfg_ff);
      if (rows_e == '0) rows_e = DW'(1);
      if (rows_e > DW'(MAX_ROWS)) rows_e = DW'(MAX_ROWS);
   end

   // Mask of columns in use, registered.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_COLS; i++) begin
         cmask_ff[i] <= (DW'(i) < cols_e);
      end
   end

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= SHIFT_W'(6);
         cols_cfg_ff <= DIM_W'(30);
         rows_cfg_ff <= DIM_W'(17);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TILE_SHIFT: shift_ff    <= csr_wdata[SHIFT_W-1:0];
            CSR_COLS:       cols_cfg_ff <= csr_wdata[DIM_W-1:0];
            CSR_ROWS:       rows_cfg_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Corner tiles of a mark item, clamped.
   logic [PIX_W-1:0] tx0, ty0, tx1, ty1;
   logic [PIX_W-1:0] lastc, lastr;
   logic [PIX_W-1:0] cx0, cx1, cy0, cy1;
   always_comb begin
      tx0 = req_x_first >> sh;
      ty0 = req_y_first >> sh;
      tx1 = req_x_last >> sh;
      ty1 = req_y_last >> sh;
      lastc = PIX_W'(cols_e) - PIX_W'(1);
      lastr = PIX_W'(rows_e) - PIX_W'(1);
      cx0 = (tx0 > lastc) ? lastc : tx0;
      cx1 = (tx1 > lastc) ? lastc : tx1;
      cy0 = (ty0 > lastr) ? lastr : ty0;
      cy1 = (ty1 > lastr) ? lastr : ty1;
   end

   // Row data views.
   logic [MAX_COLS-1:0] row_live;
   logic [MAX_COLS-1:0] first_bit;
   logic [MAX_COLS-1:0] mark_mask;
   logic [CW-1:0]       first_col;
   logic                row_hit;
   always_comb begin
      row_live = rd_data_ff & cmask_ff;
      row_hit  = |row_live;
      first_bit = row_live & (~row_live + MAX_COLS'(1));
      first_col = '0;
      for (int i = 0; i < MAX_COLS; i++) begin
         if (first_bit[i]) first_col = CW'(i);
      end
      for (int i = 0; i < MAX_COLS; i++) begin
         mark_mask[i] = (CW'(i) >= x0_ff) && (CW'(i) <= x1_ff);
      end
   end

   // Column group after the first column: contiguous run of still-set bits from x0.
   logic [MAX_COLS-1:0] grp;
   logic [CW-1:0]       ex;
   always_comb begin
      grp = '0;
      ex  = x0_ff;
      for (int i = 0; i < MAX_COLS; i++) begin
         if (CW'(i) == x0_ff) grp[i] = 1'b1;
      end
      for (int i = 1; i < MAX_COLS; i++) begin
         if (CW'(i) > x0_ff && grp[i-1] && mask_ff[i]) begin
            grp[i] = 1'b1;
            ex = CW'(i);
         end
      end
   end

   logic [RN-1:0] row_nxt;
   assign row_nxt = row_ff + RN'(1);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      rv_in = 1'b0;
      rrow_in = rrow_ff;
      x0_in = x0_ff; x1_in = x1_ff; y1_in = y1_ff;
      sy_in = sy_ff; ey_in = ey_ff; mask_in = mask_ff;
      mem_we = 1'b0; mem_waddr = row_ff[RW-1:0]; mem_wdata = '0;
      mem_re = 1'b0; mem_raddr = row_ff[RW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            row_in = row_nxt;
            if (row_nxt == RN'(MAX_ROWS)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && !busy) begin
               if (req_opcode == OP_MARK) begin
                  x0_in = cx0[CW-1:0];
                  x1_in = cx1[CW-1:0];
                  y1_in = cy1[RW-1:0];
                  row_in = RN'(cy0);
                  if (cx0 <= cx1 && cy0 <= cy1) state_in = ST_MARK;
               end else begin
                  row_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_MARK: begin
            // Read row, then write it back with the span set.
            if (rv_ff) begin
               mem_we = 1'b1;
               mem_waddr = rrow_ff;
               mem_wdata = rd_data_ff | mark_mask;
               state_in = ST_IDLE;
            end else begin
               mem_re = 1'b1;
               rv_in = 1'b1;
               rrow_in = row_ff[RW-1:0];
            end
            if (rv_ff && rrow_ff != y1_ff) begin
               state_in = ST_MARK;
               rv_in = 1'b0;
               row_in = RN'(rrow_ff) + RN'(1);
            end
         end
         ST_SCAN: begin
            // Issue a read of the next row; check the returned row.
            if (rv_ff && row_hit) begin
               x0_in = first_col;
               sy_in = rrow_ff;
               ey_in = rrow_ff;
               mask_in = row_live;
               row_in = RN'(rrow_ff) + RN'(1);
               state_in = ST_RUN;
            end else if (row_ff < RN'(rows_e)) begin
               mem_re = 1'b1;
               rv_in = 1'b1;
               rrow_in = row_ff[RW-1:0];
               row_in = row_nxt;
            end else if (!rv_ff || !row_hit) begin
               if (!rv_ff || RN'(rrow_ff) + RN'(1) >= RN'(rows_e)) state_in = ST_EMPTY;
            end
         end
         ST_RUN: begin
            // Extend the run down the first column; prune group columns below.
            if (rv_ff) begin
               if (rd_data_ff[x0_ff]) begin
                  ey_in = rrow_ff;
                  mask_in = mask_ff & rd_data_ff;
               end else begin
                  mask_in = mask_ff & ~rd_data_ff;
                  state_in = ST_GROW;
               end
            end
            if (!(rv_ff && !rd_data_ff[x0_ff])) begin
               if (rv_ff || row_ff == RN'(sy_ff) + RN'(1)) begin
                  if (row_ff < RN'(rows_e) && !(rv_ff && !rd_data_ff[x0_ff])) begin
                     mem_re = 1'b1;
                     rv_in = 1'b1;
                     rrow_in = row_ff[RW-1:0];
                     row_in = row_nxt;
                  end else begin
                     state_in = ST_GROW;
                  end
               end
            end
         end
         ST_GROW: begin
            x1_in = ex;
            row_in = RN'(sy_ff);
            state_in = ST_WIPE;
         end
         ST_WIPE: begin
            if (rv_ff) begin
               mem_we = 1'b1;
               mem_waddr = rrow_ff;
               mem_wdata = rd_data_ff & ~mark_mask;
               if (rrow_ff == ey_ff) state_in = ST_DONE;
               else row_in = RN'(rrow_ff) + RN'(1);
            end else begin
               mem_re = 1'b1;
               rv_in = 1'b1;
               rrow_in = row_ff[RW-1:0];
            end
         end
         ST_DONE:  state_in = ST_IDLE;
         ST_EMPTY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         row_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         rv_ff    <= rv_in;
      end
      rrow_ff <= rrow_in;
      x0_ff <= x0_in; x1_ff <= x1_in; y1_ff <= y1_in;
      sy_ff <= sy_in; ey_ff <= ey_in; mask_ff <= mask_in;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_DONE) || (state_ff == ST_EMPTY);
      end
      rsp_rect_found <= (state_ff == ST_DONE);
      if (state_ff == ST_DONE) begin
         rsp_x_start <= PIX_W'(x0_ff) << sh;
         rsp_y_start <= PIX_W'(sy_ff) << sh;
         rsp_x_end   <= PIX_W'(x1_ff) << sh;
         rsp_y_end   <= PIX_W'(ey_ff) << sh;
      end else begin
         rsp_x_start <= '0;
         rsp_y_start <= '0;
         rsp_x_end   <= '0;
         rsp_y_end   <= '0;
      end
   end

   assign busy = (state_ff != ST_IDLE) || rsp_valid;

   `DTR_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == ST_DONE, rsp_valid && rsp_rect_found)
   `DTR_ASSERT_NEXT(a_empty_strobe, clock, reset, state_ff == ST_EMPTY, rsp_valid && !rsp_rect_found)
   `DTR_ASSERT_IMP(a_run_order, clock, reset, state_ff == ST_WIPE, ey_ff >= sy_ff)
   `DTR_ASSERT_IMP(a_busy_rsp, clock, reset, rsp_valid, busy)
endmodule
`default_nettype wire
